// ===== rtl/bmph_pkg.sv =====
// Package for the peak-hold bar meter: item types, register indexes,
// controller states, command/status structs and reset values.
// No dependencies.
package bmph_pkg;

    localparam int IDX_W      = 5;
    localparam int LEVEL_W    = 16;
    localparam int PX_W       = 9;
    localparam int HOLD_W     = 9;
    localparam int SEG_W      = 6;
    localparam int AMP_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = 32;
    localparam int DIV_STEPS  = PX_W;
    localparam int DIV_CNT_W  = 4;

    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    localparam logic                  RST_PEAK_MODE  = 1'b0;
    localparam logic [LEVEL_W-1:0]    RST_DECAY      = 16'd58982;
    localparam logic [AMP_W-1:0]      RST_AMP_SCALE  = 8'd64;
    localparam logic [SEG_W-1:0]      RST_SEG_HEIGHT = 6'd2;
    localparam logic [SEG_W-1:0]      RST_SEG_STEP   = 6'd3;
    localparam logic [AMP_W-1:0]      RST_HOLD       = 8'd30;
    localparam logic [LEVEL_W-1:0]    RST_FALL_STEP  = 16'd1536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PEAK_MODE  = 3'd0,
        CFG_DECAY      = 3'd1,
        CFG_AMP_SCALE  = 3'd2,
        CFG_SEG_HEIGHT = 3'd3,
        CFG_SEG_STEP   = 3'd4,
        CFG_HOLD       = 3'd5,
        CFG_FALL_STEP  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [IDX_W-1:0]   bar_index;
        logic [LEVEL_W-1:0] magnitude;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] bar_number;
        logic [PX_W-1:0]  bar_height;
        logic [PX_W-1:0]  lit_segments;
        logic [PX_W-1:0]  peak_offset;
        logic             peak_visible;
        logic             all_at_rest;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAG,
        S_DEC,
        S_SEL,
        S_LVL,
        S_SNAP,
        S_PEAK,
        S_PKMUL,
        S_DIV1,
        S_DIV1W,
        S_DIV2,
        S_DIV2W,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_MAG,
        MUL_DEC,
        MUL_LVL,
        MUL_PK
    } t_mul_op;

    typedef enum logic {
        DIV_SEG,
        DIV_PEAK
    } t_div_op;

    typedef struct packed {
        logic    accept;
        logic    mul_en;
        t_mul_op mul_op;
        logic    gate_en;
        logic    sel_en;
        logic    snap_en;
        logic    peak_en;
        logic    wb_en;
        logic    div_start;
        t_div_op div_op;
        logic    seg_cap;
        logic    poff_cap;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic in_range;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/bar_meter_peak_hold.sv =====
// Peak-hold bar level meter. Each input item (bar index, Q1.15 magnitude)
// updates its bar if the index is in range and yields one result item with
// bar height, lit segment count, snapped peak offset, peak visibility and an
// all-at-rest flag. Seven steps run four products through one shared 16x16
// multiplier. Two serial divisions by the segment step follow, and then the
// output register is loaded. The input is taken again in the cycle after the
// load, not before. An index beyond the bar count skips from the first
// multiply step to the result. A new item is taken while the previous result
// waits in the output register. That item then waits before the load until
// the register frees. Configuration is to be written by the user through
// i_cfg_we/i_cfg_index/i_cfg_data while the block is idle; the block does not
// enforce this. Depends on bmph_pkg, bmph_ctrl and bmph_datapath.
module bar_meter_peak_hold #(
    parameter int BAR_COUNT = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bmph_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bmph_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    input  bmph_pkg::t_in_item                 i_in_item,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output bmph_pkg::t_out_item                o_out_item,
    input  logic                               i_out_stall
);

    bmph_pkg::t_dp_cmd    cmd;
    bmph_pkg::t_dp_status status;

    bmph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    bmph_datapath #(
        .BAR_COUNT (BAR_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/bmph_div.sv =====
// Restoring divider for pixel values by the segment step, one quotient
// bit per cycle. Depends on bmph_pkg.
module bmph_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [bmph_pkg::PX_W-1:0]    i_dividend,
    input  logic [bmph_pkg::SEG_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [bmph_pkg::PX_W-1:0]    o_quotient,
    output logic [bmph_pkg::SEG_W-1:0]   o_remainder
);

    logic [bmph_pkg::PX_W-1:0]      r_quo, n_quo;
    logic [bmph_pkg::SEG_W-1:0]     r_rem, n_rem;
    logic [bmph_pkg::SEG_W-1:0]     r_div;
    logic [bmph_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [bmph_pkg::SEG_W:0]       trial;
    logic [bmph_pkg::SEG_W:0]       diff;

    always_comb begin
        trial = {r_rem, r_quo[bmph_pkg::PX_W-1]};
        diff  = trial - {1'b0, r_div};
        if (trial >= {1'b0, r_div}) begin
            n_rem = diff[bmph_pkg::SEG_W-1:0];
            n_quo = {r_quo[bmph_pkg::PX_W-2:0], 1'b1};
        end else begin
            n_rem = trial[bmph_pkg::SEG_W-1:0];
            n_quo = {r_quo[bmph_pkg::PX_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == bmph_pkg::DIV_CNT_W'(bmph_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

    a_start_clears_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> !r_done && r_busy)
        else $error("divider start did not begin a new division");

    a_remainder_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_rem < r_div)
        else $error("divider remainder not below divisor");

endmodule

// ===== rtl/bmph_ctrl.sv =====
// Controller for the peak-hold bar meter: sequences multiply, update,
// divide and result steps for one item. Depends on bmph_pkg.
module bmph_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  bmph_pkg::t_dp_status  i_status,
    output bmph_pkg::t_dp_cmd     o_cmd,
    output logic                  o_in_stall
);

    bmph_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmph_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            bmph_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = bmph_pkg::S_MAG;
                end
            end
            bmph_pkg::S_MAG: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = bmph_pkg::MUL_MAG;
                n_state      = i_status.in_range ? bmph_pkg::S_DEC : bmph_pkg::S_DONE;
            end
            bmph_pkg::S_DEC: begin
                o_cmd.gate_en = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_op  = bmph_pkg::MUL_DEC;
                n_state       = bmph_pkg::S_SEL;
            end
            bmph_pkg::S_SEL: begin
                o_cmd.sel_en = 1'b1;
                n_state      = bmph_pkg::S_LVL;
            end
            bmph_pkg::S_LVL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = bmph_pkg::MUL_LVL;
                n_state      = bmph_pkg::S_SNAP;
            end
            bmph_pkg::S_SNAP: begin
                o_cmd.snap_en = 1'b1;
                n_state       = bmph_pkg::S_PEAK;
            end
            bmph_pkg::S_PEAK: begin
                o_cmd.peak_en = 1'b1;
                n_state       = bmph_pkg::S_PKMUL;
            end
            bmph_pkg::S_PKMUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = bmph_pkg::MUL_PK;
                o_cmd.wb_en  = 1'b1;
                n_state      = bmph_pkg::S_DIV1;
            end
            bmph_pkg::S_DIV1: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = bmph_pkg::DIV_SEG;
                n_state         = bmph_pkg::S_DIV1W;
            end
            bmph_pkg::S_DIV1W: begin
                if (i_status.div_done) begin
                    o_cmd.seg_cap = 1'b1;
                    n_state       = bmph_pkg::S_DIV2;
                end
            end
            bmph_pkg::S_DIV2: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = bmph_pkg::DIV_PEAK;
                n_state         = bmph_pkg::S_DIV2W;
            end
            bmph_pkg::S_DIV2W: begin
                if (i_status.div_done) begin
                    o_cmd.poff_cap = 1'b1;
                    n_state        = bmph_pkg::S_DONE;
                end
            end
            bmph_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = bmph_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bmph_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != bmph_pkg::S_IDLE);

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == bmph_pkg::S_MAG)
        else $error("accepted item did not start the sequence");

    a_writeback_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wb_en |=> !o_cmd.wb_en && r_state == bmph_pkg::S_DIV1)
        else $error("state write-back not followed by division");

    a_load_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> !o_in_stall)
        else $error("result load did not free the input side");

endmodule

// ===== rtl/bmph_datapath.sv =====
// Datapath for the peak-hold bar meter: configuration registers, per-bar
// state, shared multiplier, divider and output register.
// Depends on bmph_pkg and bmph_div.
module bmph_datapath #(
    parameter int BAR_COUNT = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bmph_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bmph_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  bmph_pkg::t_in_item                 i_in_item,
    input  bmph_pkg::t_dp_cmd                  i_cmd,
    output bmph_pkg::t_dp_status               o_status,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output bmph_pkg::t_out_item                o_out_item
);

    // Only the first 32 bars are reachable through a 5-bit index.
    localparam int BAR_DEPTH = (BAR_COUNT < (1 << bmph_pkg::IDX_W)) ? BAR_COUNT
                                                                   : (1 << bmph_pkg::IDX_W);
    localparam int ADDR_W    = (BAR_DEPTH > 1) ? $clog2(BAR_DEPTH) : 1;

    localparam int LW = bmph_pkg::LEVEL_W;
    localparam int PW = bmph_pkg::PX_W;
    localparam int SW = bmph_pkg::SEG_W;

    // configuration
    logic                         r_peak_mode;
    logic [LW-1:0]                r_decay;
    logic [bmph_pkg::AMP_W-1:0]   r_amp;
    logic [SW-1:0]                r_seg_h;
    logic [SW-1:0]                r_seg_step;
    logic [bmph_pkg::AMP_W-1:0]   r_hold;
    logic [LW-1:0]                r_fall;

    // per-bar state
    logic [LW-1:0]                r_bar_lvl  [0:BAR_DEPTH-1];
    logic [LW-1:0]                r_bar_pk   [0:BAR_DEPTH-1];
    logic [bmph_pkg::HOLD_W-1:0]  r_bar_hc   [0:BAR_DEPTH-1];
    logic [BAR_DEPTH-1:0]         r_mask;

    // working registers for one item
    logic [bmph_pkg::IDX_W-1:0]   r_idx;
    logic                         r_in_range;
    logic [LW-1:0]                r_mag;
    logic [LW-1:0]                r_lvl;
    logic [LW-1:0]                r_pk;
    logic [bmph_pkg::HOLD_W-1:0]  r_hc;
    logic                         r_rise;
    logic [bmph_pkg::PROD_W-1:0]  r_prod;
    logic [PW-1:0]                r_height;
    logic [PW-1:0]                r_segs;
    logic [PW-1:0]                r_poff;

    logic                         r_out_valid;
    bmph_pkg::t_out_item          r_out_item;

    logic [ADDR_W-1:0]            rd_addr;
    logic [ADDR_W-1:0]            wr_addr;
    logic                         in_range_in;
    logic [LW-1:0]                mul_a;
    logic [LW-1:0]                mul_b;
    logic [bmph_pkg::PROD_W-1:0]  thresh;
    logic                         below_seg;
    logic [SW-1:0]                step_eff;
    logic [PW-1:0]                pk_px;
    logic [PW-1:0]                dividend;
    logic                         div_done;
    logic [PW-1:0]                div_quo;
    logic [SW-1:0]                div_rem;
    logic [bmph_pkg::HOLD_W-1:0]  hc_inc;
    logic                         height_ge;
    logic                         out_free;

    assign rd_addr     = i_in_item.bar_index[ADDR_W-1:0];
    assign wr_addr     = r_idx[ADDR_W-1:0];
    assign in_range_in = (32'(i_in_item.bar_index) < BAR_COUNT);
    assign thresh      = bmph_pkg::PROD_W'({r_seg_h, 15'b0});
    assign below_seg   = (r_prod < thresh);
    assign step_eff    = (r_seg_step == '0) ? SW'(1) : r_seg_step;
    assign pk_px       = r_prod[15 +: PW];
    assign hc_inc      = (r_hc == bmph_pkg::HOLD_MAX) ? r_hc : r_hc + 1'b1;
    assign height_ge   = (r_height >= PW'(r_seg_h));
    assign out_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_mode <= bmph_pkg::RST_PEAK_MODE;
            r_decay     <= bmph_pkg::RST_DECAY;
            r_amp       <= bmph_pkg::RST_AMP_SCALE;
            r_seg_h     <= bmph_pkg::RST_SEG_HEIGHT;
            r_seg_step  <= bmph_pkg::RST_SEG_STEP;
            r_hold      <= bmph_pkg::RST_HOLD;
            r_fall      <= bmph_pkg::RST_FALL_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bmph_pkg::CFG_PEAK_MODE:  r_peak_mode <= i_cfg_data[0];
                bmph_pkg::CFG_DECAY:      r_decay     <= i_cfg_data;
                bmph_pkg::CFG_AMP_SCALE:  r_amp       <= i_cfg_data[bmph_pkg::AMP_W-1:0];
                bmph_pkg::CFG_SEG_HEIGHT: r_seg_h     <= i_cfg_data[SW-1:0];
                bmph_pkg::CFG_SEG_STEP:   r_seg_step  <= i_cfg_data[SW-1:0];
                bmph_pkg::CFG_HOLD:       r_hold      <= i_cfg_data[bmph_pkg::AMP_W-1:0];
                bmph_pkg::CFG_FALL_STEP:  r_fall      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shared multiplier, registered
    always_comb begin
        case (i_cmd.mul_op)
            bmph_pkg::MUL_MAG: begin
                mul_a = r_mag;
                mul_b = LW'(r_amp);
            end
            bmph_pkg::MUL_DEC: begin
                mul_a = r_lvl;
                mul_b = r_decay;
            end
            bmph_pkg::MUL_LVL: begin
                mul_a = r_lvl;
                mul_b = LW'(r_amp);
            end
            default: begin
                mul_a = r_pk;
                mul_b = LW'(r_amp);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // item working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx      <= i_in_item.bar_index;
            r_in_range <= in_range_in;
            r_mag      <= i_in_item.magnitude;
            r_lvl      <= in_range_in ? r_bar_lvl[rd_addr] : '0;
            r_pk       <= in_range_in ? r_bar_pk[rd_addr]  : '0;
            r_hc       <= in_range_in ? r_bar_hc[rd_addr]  : '0;
            r_height   <= '0;
            r_segs     <= '0;
            r_poff     <= '0;
        end
        if (i_cmd.gate_en && below_seg) begin
            r_mag <= '0;
        end
        if (i_cmd.sel_en) begin
            r_rise <= (r_mag > r_lvl);
            r_lvl  <= (r_mag > r_lvl) ? r_mag : r_prod[LW +: LW];
        end
        if (i_cmd.snap_en) begin
            // drop a decayed level that no longer fills one segment
            if (!r_rise && below_seg) begin
                r_lvl    <= '0;
                r_height <= '0;
            end else begin
                r_height <= r_prod[15 +: PW];
            end
        end
        if (i_cmd.peak_en) begin
            if (!r_peak_mode) begin
                r_pk <= '0;
                r_hc <= '0;
            end else if (r_lvl > r_pk) begin
                r_pk <= r_lvl;
                r_hc <= '0;
            end else begin
                r_hc <= hc_inc;
                if (hc_inc > bmph_pkg::HOLD_W'(r_hold)) begin
                    r_pk <= (r_pk > r_fall) ? r_pk - r_fall : '0;
                end
            end
        end
        if (i_cmd.seg_cap) begin
            r_segs <= height_ge ? div_quo + 1'b1 : '0;
        end
        if (i_cmd.poff_cap) begin
            // round down to a step multiple: value minus remainder
            r_poff <= pk_px - PW'(div_rem);
        end
    end

    // per-bar state and activity mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BAR_DEPTH; i++) begin
                r_bar_lvl[i] <= '0;
                r_bar_pk[i]  <= '0;
                r_bar_hc[i]  <= '0;
            end
            r_mask <= '0;
        end else if (i_cmd.wb_en) begin
            r_bar_lvl[wr_addr] <= r_lvl;
            r_bar_pk[wr_addr]  <= r_pk;
            r_bar_hc[wr_addr]  <= r_hc;
            r_mask[wr_addr]    <= (r_lvl != '0) || (r_pk != '0);
        end
    end

    assign dividend = (i_cmd.div_op == bmph_pkg::DIV_SEG) ? r_height - PW'(r_seg_h) : pk_px;

    bmph_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (dividend),
        .i_divisor   (step_eff),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_item.bar_number   <= r_idx;
            r_out_item.bar_height   <= r_height;
            r_out_item.lit_segments <= r_segs;
            r_out_item.peak_offset  <= r_poff;
            r_out_item.peak_visible <= r_peak_mode && (r_poff > r_height);
            r_out_item.all_at_rest  <= (r_mask == '0);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out_item;
    assign o_status.in_range = r_in_range;
    assign o_status.div_done = div_done;
    assign o_status.out_free = out_free;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("result register overwritten while held");

    a_peak_off_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wb_en && !r_peak_mode |-> r_pk == '0 && r_hc == '0)
        else $error("peak state kept with peak mode off");

    a_mask_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wb_en |=> r_mask[$past(wr_addr)] == (($past(r_lvl) != '0) || ($past(r_pk) != '0)))
        else $error("activity mask out of step with bar state");

endmodule
